FILE: hw/rtl/kmm_pkg.sv
// Shared types and constants for the key-to-mouse event mapper.
// No dependencies; the matcher, the top level and the checker use it.
`default_nettype none

package kmm_pkg;

	localparam int unsigned KEY_W     = 8;
	localparam int unsigned SPEED_W   = 6;
	localparam int unsigned LIMIT_W   = 5;
	localparam int unsigned WHEEL_W   = 8;
	localparam int unsigned CFG_W     = 32;
	localparam int unsigned NUM_SLOTS = 9;
	localparam int unsigned NUM_BTNS  = 3;

	localparam logic [LIMIT_W-1:0]        SPEED_LIMIT_RESET = 5'd20;
	localparam logic signed [WHEEL_W-1:0] WHEEL_STEP        = 8'sd120;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_MOVE_KEYS   = 2'd0,
		REG_BUTTON_KEYS = 2'd1,
		REG_SCROLL_KEYS = 2'd2,
		REG_SPEED_LIMIT = 2'd3
	} reg_idx_t;

	// Result event kinds.
	typedef enum logic [1:0] {
		EV_MOVE     = 2'd0,
		EV_BTN_DOWN = 2'd1,
		EV_BTN_UP   = 2'd2,
		EV_WHEEL    = 2'd3
	} event_kind_t;

	// Key slots in priority order, lowest code wins.
	typedef enum logic [3:0] {
		SLOT_MOVE_LEFT   = 4'd0,
		SLOT_MOVE_RIGHT  = 4'd1,
		SLOT_MOVE_UP     = 4'd2,
		SLOT_MOVE_DOWN   = 4'd3,
		SLOT_BTN_LEFT    = 4'd4,
		SLOT_BTN_RIGHT   = 4'd5,
		SLOT_BTN_MIDDLE  = 4'd6,
		SLOT_SCROLL_UP   = 4'd7,
		SLOT_SCROLL_DOWN = 4'd8
	} slot_t;

	// Button indexes as reported on the result channel.
	typedef enum logic [1:0] {
		BTN_LEFT   = 2'd0,
		BTN_RIGHT  = 2'd1,
		BTN_MIDDLE = 2'd2
	} button_t;

	// Outcome of the key code lookup.
	typedef struct packed {
		logic  hit;
		slot_t slot;
	} match_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kmm_match.sv
// Priority matcher: compares a key code against the nine configured codes.
// Depends on kmm_pkg.
`default_nettype none

module kmm_match (
	input  wire logic [kmm_pkg::KEY_W-1:0]  key,
	input  wire logic [31:0]                move_codes,
	input  wire logic [23:0]                button_codes,
	input  wire logic [15:0]                scroll_codes,
	output kmm_pkg::match_t                 match
);

	logic [kmm_pkg::NUM_SLOTS-1:0][kmm_pkg::KEY_W-1:0] codes;

	assign codes = {scroll_codes, button_codes, move_codes};

	// Walk from the lowest priority up so the earliest matching slot wins.
	always_comb begin
		match.hit  = 1'b0;
		match.slot = kmm_pkg::SLOT_MOVE_LEFT;
		for (int i = kmm_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (codes[i] == key) begin
				match.hit  = 1'b1;
				match.slot = kmm_pkg::slot_t'(4'(i));
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/key_to_mouse_event_mapper_top.sv
// Top level of the key-to-mouse event mapper: input register, action logic,
// speed and button state, result register. Depends on kmm_pkg and kmm_match.
`default_nettype none

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   key_code, released
// result    out        out_valid / out_ready event_kind, button_index, move_x,
//                                            move_y, wheel_amount
// config    in         cfg_we (no wait)      cfg_index, cfg_data
//
// Each key transaction is captured in an input register and resolved there by
// the action logic; an event then loads the result register, from which it is
// offered on the result channel.
// One transaction is taken every cycle unless a stalled result holds it back.
// The speed and button state update as an item leaves the input register, so
// the item right behind it already sees the new state.
// A stalled result only holds the input register when that item also produces
// an event; items that produce nothing drain regardless.
// Reset clears the valid flags, the speeds and the held buttons, sets the key
// codes to zero and the speed limit to 20. No clearing pass is needed.

module key_to_mouse_event_mapper_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,

	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [kmm_pkg::KEY_W-1:0]          key_code,
	input  wire logic                               released,

	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [1:0]                              event_kind,
	output logic [1:0]                              button_index,
	output logic signed [kmm_pkg::SPEED_W-1:0]      move_x,
	output logic signed [kmm_pkg::SPEED_W-1:0]      move_y,
	output logic signed [kmm_pkg::WHEEL_W-1:0]      wheel_amount,

	input  wire logic                               cfg_we,
	input  wire logic [1:0]                         cfg_index,
	input  wire logic [kmm_pkg::CFG_W-1:0]          cfg_data
);

	// Configuration registers.
	logic [31:0]                   move_codes_q;
	logic [23:0]                   button_codes_q;
	logic [15:0]                   scroll_codes_q;
	logic [kmm_pkg::LIMIT_W-1:0]   speed_limit_q;

	// Mouse state.
	logic signed [kmm_pkg::SPEED_W-1:0] speed_x_q;
	logic signed [kmm_pkg::SPEED_W-1:0] speed_y_q;
	logic [kmm_pkg::NUM_BTNS-1:0]       held_q;

	// Input stage.
	logic                          valid_s1;
	logic [kmm_pkg::KEY_W-1:0]     key_s1;
	logic                          released_s1;

	// Result register.
	logic                                   out_valid_q;
	kmm_pkg::event_kind_t                   kind_q;
	logic [1:0]                             btn_q;
	logic signed [kmm_pkg::SPEED_W-1:0]     mx_q;
	logic signed [kmm_pkg::SPEED_W-1:0]     my_q;
	logic signed [kmm_pkg::WHEEL_W-1:0]     wheel_q;

	// Action logic outputs.
	kmm_pkg::match_t                        match;
	logic                                   emit;
	kmm_pkg::event_kind_t                   kind_d;
	logic [1:0]                             btn_d;
	logic signed [kmm_pkg::SPEED_W-1:0]     mx_d;
	logic signed [kmm_pkg::SPEED_W-1:0]     my_d;
	logic signed [kmm_pkg::WHEEL_W-1:0]     wheel_d;
	logic signed [kmm_pkg::SPEED_W-1:0]     speed_x_d;
	logic signed [kmm_pkg::SPEED_W-1:0]     speed_y_d;
	logic [kmm_pkg::NUM_BTNS-1:0]           held_d;
	logic                                   advance;

	// One speed step toward the limit in the given direction. A speed of the
	// opposite sign is dropped to zero first; a speed already at or beyond
	// the limit is left as it is.
	function automatic logic signed [kmm_pkg::SPEED_W-1:0] step_speed(
		input logic signed [kmm_pkg::SPEED_W-1:0] v,
		input logic                               up,
		input logic [kmm_pkg::LIMIT_W-1:0]        lim
	);
		logic signed [kmm_pkg::SPEED_W-1:0] lim_s;
		logic signed [kmm_pkg::SPEED_W-1:0] w;
		begin
			lim_s = $signed({1'b0, lim});
			w     = v;
			if (up) begin
				if (w < 0)
					w = '0;
				if (w < lim_s)
					w = w + 6'sd1;
			end else begin
				if (w > 0)
					w = '0;
				if (w > -lim_s)
					w = w - 6'sd1;
			end
			return w;
		end
	endfunction

	kmm_match u_match (
		.key          (key_s1),
		.move_codes   (move_codes_q),
		.button_codes (button_codes_q),
		.scroll_codes (scroll_codes_q),
		.match        (match)
	);

	// Decide what the item in the input register does.
	always_comb begin
		emit      = 1'b0;
		kind_d    = kmm_pkg::EV_MOVE;
		btn_d     = '0;
		mx_d      = '0;
		my_d      = '0;
		wheel_d   = '0;
		speed_x_d = speed_x_q;
		speed_y_d = speed_y_q;
		held_d    = held_q;
		if (match.hit) begin
			case (match.slot) inside
				kmm_pkg::SLOT_MOVE_LEFT, kmm_pkg::SLOT_MOVE_RIGHT: begin
					if (released_s1) begin
						speed_x_d = '0;
					end else begin
						speed_x_d = step_speed(speed_x_q,
							match.slot == kmm_pkg::SLOT_MOVE_RIGHT, speed_limit_q);
						mx_d = speed_x_d;
						emit = 1'b1;
					end
				end
				kmm_pkg::SLOT_MOVE_UP, kmm_pkg::SLOT_MOVE_DOWN: begin
					if (released_s1) begin
						speed_y_d = '0;
					end else begin
						speed_y_d = step_speed(speed_y_q,
							match.slot == kmm_pkg::SLOT_MOVE_DOWN, speed_limit_q);
						my_d = speed_y_d;
						emit = 1'b1;
					end
				end
				kmm_pkg::SLOT_BTN_LEFT, kmm_pkg::SLOT_BTN_RIGHT,
				kmm_pkg::SLOT_BTN_MIDDLE: begin
					case (match.slot)
						kmm_pkg::SLOT_BTN_LEFT:  btn_d = kmm_pkg::BTN_LEFT;
						kmm_pkg::SLOT_BTN_RIGHT: btn_d = kmm_pkg::BTN_RIGHT;
						default:                 btn_d = kmm_pkg::BTN_MIDDLE;
					endcase
					// A repeated press of a held button is swallowed.
					if (released_s1 || !held_q[btn_d]) begin
						held_d[btn_d] = !released_s1;
						kind_d = released_s1 ? kmm_pkg::EV_BTN_UP : kmm_pkg::EV_BTN_DOWN;
						emit   = 1'b1;
					end
				end
				kmm_pkg::SLOT_SCROLL_UP, kmm_pkg::SLOT_SCROLL_DOWN: begin
					if (!released_s1) begin
						kind_d  = kmm_pkg::EV_WHEEL;
						wheel_d = (match.slot == kmm_pkg::SLOT_SCROLL_UP) ?
							kmm_pkg::WHEEL_STEP : -kmm_pkg::WHEEL_STEP;
						emit    = 1'b1;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	// The input register drains when its item yields nothing or the result
	// register has room this cycle.
	assign advance  = !emit || !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_s1      <= key_code;
			released_s1 <= released;
		end
	end

	// Configuration writes and mouse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_codes_q   <= '0;
			button_codes_q <= '0;
			scroll_codes_q <= '0;
			speed_limit_q  <= kmm_pkg::SPEED_LIMIT_RESET;
			speed_x_q      <= '0;
			speed_y_q      <= '0;
			held_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (kmm_pkg::reg_idx_t'(cfg_index))
					kmm_pkg::REG_MOVE_KEYS:   move_codes_q   <= cfg_data;
					kmm_pkg::REG_BUTTON_KEYS: button_codes_q <= cfg_data[23:0];
					kmm_pkg::REG_SCROLL_KEYS: scroll_codes_q <= cfg_data[15:0];
					kmm_pkg::REG_SPEED_LIMIT:
						speed_limit_q <= cfg_data[kmm_pkg::LIMIT_W-1:0];
				endcase
			end
			if (valid_s1 && advance) begin
				speed_x_q <= speed_x_d;
				speed_y_q <= speed_y_d;
				held_q    <= held_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && emit) begin
			kind_q  <= kind_d;
			btn_q   <= btn_d;
			mx_q    <= mx_d;
			my_q    <= my_d;
			wheel_q <= wheel_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = kind_q;
	assign button_index = btn_q;
	assign move_x       = mx_q;
	assign move_y       = my_q;
	assign wheel_amount = wheel_q;

endmodule

`default_nettype wire

FILE: hw/rtl/kmm_checker.sv
// Port-level checker for the key-to-mouse event mapper, bound to the top level.
// Depends on kmm_pkg and key_to_mouse_event_mapper_top.
`default_nettype none

module kmm_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [1:0]                   event_kind,
	input wire logic [1:0]                   button_index,
	input wire logic signed [5:0]            move_x,
	input wire logic signed [5:0]            move_y,
	input wire logic signed [7:0]            wheel_amount
);

	// A pending result is not withdrawn.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A move touches one axis only and carries no button or wheel.
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == kmm_pkg::EV_MOVE |->
		wheel_amount == 0 && button_index == 0 && (move_x == 0 || move_y == 0))
		else $error("malformed move event");

	// Button events name a real button and carry no motion.
	a_button: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == kmm_pkg::EV_BTN_DOWN ||
		event_kind == kmm_pkg::EV_BTN_UP) |->
		button_index != 2'd3 && move_x == 0 && move_y == 0 && wheel_amount == 0)
		else $error("malformed button event");

	// Wheel events are exactly one notch.
	a_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == kmm_pkg::EV_WHEEL |->
		(wheel_amount == 8'sd120 || wheel_amount == -8'sd120) &&
		move_x == 0 && move_y == 0 && button_index == 0)
		else $error("malformed wheel event");

endmodule

bind key_to_mouse_event_mapper_top kmm_checker u_kmm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.event_kind   (event_kind),
	.button_index (button_index),
	.move_x       (move_x),
	.move_y       (move_y),
	.wheel_amount (wheel_amount)
);

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for key_to_mouse_event_mapper_top.
// Holds a scoreboard class that predicts mouse events from key transactions.
// Depends on kmm_pkg and the RTL top level only.
`timescale 1ns / 1ps

import kmm_pkg::*;

typedef struct packed {
	event_kind_t               kind;
	button_t                   button;
	logic signed [SPEED_W-1:0] dx;
	logic signed [SPEED_W-1:0] dy;
	logic signed [WHEEL_W-1:0] wheel;
} mouse_event_t;

class mouse_key_scoreboard;
	logic [31:0]  move_codes;
	logic [23:0]  button_codes;
	logic [15:0]  scroll_codes;
	logic [4:0]   speed_cap;
	int           speed_x;
	int           speed_y;
	bit           held [NUM_BTNS];
	mouse_event_t pending_events [$];
	int           mismatches;

	function new();
		move_codes   = '0;
		button_codes = '0;
		scroll_codes = '0;
		speed_cap    = SPEED_LIMIT_RESET;
		speed_x      = 0;
		speed_y      = 0;
		held         = '{default: 1'b0};
		mismatches   = 0;
	endfunction

	function void write_reg(reg_idx_t idx, logic [31:0] value);
		case (idx)
			REG_MOVE_KEYS:   move_codes   = value;
			REG_BUTTON_KEYS: button_codes = value[23:0];
			REG_SCROLL_KEYS: scroll_codes = value[15:0];
			REG_SPEED_LIMIT: speed_cap    = value[4:0];
		endcase
	endfunction

	function logic [7:0] slot_code(int s);
		if (s < SLOT_BTN_LEFT)
			return move_codes[8*s +: 8];
		if (s < SLOT_SCROLL_UP)
			return button_codes[8*(s - SLOT_BTN_LEFT) +: 8];
		return scroll_codes[8*(s - SLOT_SCROLL_UP) +: 8];
	endfunction

	// An opposite-sign speed clears first; a speed already at or past the
	// cap is left alone.
	function int stepped(int v, bit up);
		int cap;
		cap = speed_cap;
		if (up) begin
			if (v < 0)
				v = 0;
			if (v < cap)
				v++;
		end else begin
			if (v > 0)
				v = 0;
			if (v > -cap)
				v--;
		end
		return v;
	endfunction

	function void note_key(logic [7:0] key, logic rel);
		int           hit;
		int           b;
		mouse_event_t ev;
		hit = -1;
		for (int s = 0; s < NUM_SLOTS && hit < 0; s++)
			if (slot_code(s) == key)
				hit = s;
		if (hit < 0)
			return;
		ev        = '0;
		ev.kind   = EV_MOVE;
		ev.button = BTN_LEFT;
		case (slot_t'(hit)) inside
			SLOT_MOVE_LEFT, SLOT_MOVE_RIGHT: begin
				if (rel) begin
					speed_x = 0;
					return;
				end
				speed_x = stepped(speed_x, hit == SLOT_MOVE_RIGHT);
				ev.dx   = SPEED_W'(speed_x);
			end
			SLOT_MOVE_UP, SLOT_MOVE_DOWN: begin
				if (rel) begin
					speed_y = 0;
					return;
				end
				speed_y = stepped(speed_y, hit == SLOT_MOVE_DOWN);
				ev.dy   = SPEED_W'(speed_y);
			end
			SLOT_BTN_LEFT, SLOT_BTN_RIGHT, SLOT_BTN_MIDDLE: begin
				b = hit - SLOT_BTN_LEFT;
				if (!rel && held[b])
					return;
				held[b]   = !rel;
				ev.kind   = rel ? EV_BTN_UP : EV_BTN_DOWN;
				ev.button = button_t'(b);
			end
			default: begin
				if (rel)
					return;
				ev.kind  = EV_WHEEL;
				ev.wheel = (hit == SLOT_SCROLL_UP) ? WHEEL_STEP : -WHEEL_STEP;
			end
		endcase
		pending_events.push_back(ev);
	endfunction

	task report(string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task check_event(logic [1:0] kind, logic [1:0] btn, logic signed [SPEED_W-1:0] dx,
			logic signed [SPEED_W-1:0] dy, logic signed [WHEEL_W-1:0] wheel);
		mouse_event_t want;
		if (pending_events.size() == 0) begin
			report($sformatf("event kind %0d with nothing due", kind));
			return;
		end
		want = pending_events.pop_front();
		if (kind !== want.kind)
			report($sformatf("event_kind %0d, due %0d", kind, want.kind));
		if (btn !== want.button)
			report($sformatf("button_index %0d, due %0d", btn, want.button));
		if (dx !== want.dx)
			report($sformatf("move_x %0d, due %0d", dx, want.dx));
		if (dy !== want.dy)
			report($sformatf("move_y %0d, due %0d", dy, want.dy));
		if (wheel !== want.wheel)
			report($sformatf("wheel_amount %0d, due %0d", wheel, want.wheel));
	endtask
endclass

module tb;

	// Key codes used by the directed part: arrows move, three keys act as
	// buttons (the middle one sits on the top code), page keys scroll.
	localparam logic [7:0] KEY_LEFT   = 8'h25;
	localparam logic [7:0] KEY_UP     = 8'h26;
	localparam logic [7:0] KEY_RIGHT  = 8'h27;
	localparam logic [7:0] KEY_DOWN   = 8'h28;
	localparam logic [7:0] KEY_BTN_L  = 8'h01;
	localparam logic [7:0] KEY_BTN_R  = 8'h02;
	localparam logic [7:0] KEY_BTN_M  = 8'hFF;
	localparam logic [7:0] KEY_WHL_UP = 8'h21;
	localparam logic [7:0] KEY_WHL_DN = 8'h22;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	wire                       in_ready;
	logic [KEY_W-1:0]          key_code;
	logic                      released;
	wire                       out_valid;
	logic                      out_ready;
	wire [1:0]                 event_kind;
	wire [1:0]                 button_index;
	wire signed [SPEED_W-1:0]  move_x;
	wire signed [SPEED_W-1:0]  move_y;
	wire signed [WHEEL_W-1:0]  wheel_amount;
	logic                      cfg_we;
	logic [1:0]                cfg_index;
	logic [CFG_W-1:0]          cfg_data;

	mouse_key_scoreboard sb;

	// Idling controls, in percent of cycles; changed only between phases.
	int idle_pct;
	int stall_pct;
	// The main process raises hold_req once; the receiver process owns the
	// countdown of the long hold-off.
	bit hold_req;
	int hold_left;

	key_to_mouse_event_mapper_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_code     (key_code),
		.released     (released),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_kind   (event_kind),
		.button_index (button_index),
		.move_x       (move_x),
		.move_y       (move_y),
		.wheel_amount (wheel_amount),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Receiver side. Everything is driven with nonblocking assignments at the
	// rising edge, so every process that samples at that edge sees the values
	// from before it. During the long hold-off the block fills and drops
	// in_ready while the sender keeps offering transactions.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = 60;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Every accepted result transaction is checked against the oldest
	// predicted event.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_event(event_kind, button_index, move_x, move_y, wheel_amount);
	end

	// Offers one key transaction and returns at the edge where it is taken.
	// A random gap with in_valid low may come first. The valid is never
	// lowered here after acceptance, so back-to-back transactions keep it high
	// without a second assignment in the same step.
	task automatic send_key(input logic [7:0] k, input logic r);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		key_code <= k;
		released <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_key(k, r);
	endtask

	// Stops offering and waits until every predicted event has arrived, plus
	// a few cycles for transactions that produce nothing and may still be in
	// the two-stage pipeline.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	// Writes all four registers on consecutive edges; only called while the
	// block is idle.
	task automatic program_regs(input logic [31:0] mv, input logic [23:0] bt,
			input logic [15:0] sc, input logic [4:0] cap);
		write_reg(REG_MOVE_KEYS, mv);
		write_reg(REG_BUTTON_KEYS, {8'h00, bt});
		write_reg(REG_SCROLL_KEYS, {16'h0000, sc});
		write_reg(REG_SPEED_LIMIT, {27'd0, cap});
		cfg_we <= 1'b0;
	endtask

	// Mostly configured keys, so that speeds ramp and buttons toggle; now and
	// then a long run of presses on one move key to reach the speed cap, and
	// some random codes as noise. Only configured keys count toward n.
	task automatic random_items(input int n);
		int          done;
		int          run;
		int          s;
		logic [7:0]  k;
		done = 0;
		while (done < n) begin
			if ($urandom_range(99) < 15) begin
				s   = $urandom_range(SLOT_MOVE_DOWN);
				run = $urandom_range(35, 5);
				repeat (run) send_key(sb.slot_code(s), 1'b0);
				done += run;
			end else if ($urandom_range(99) < 80) begin
				k = sb.slot_code($urandom_range(SLOT_SCROLL_DOWN));
				send_key(k, $urandom_range(99) < 35);
				done++;
			end else begin
				k = 8'($urandom);
				send_key(k, 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		logic [4:0] cap;
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		key_code  = '0;
		released  = 1'b0;
		out_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_MOVE_KEYS;
		cfg_data  = '0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_req  = 1'b0;
		hold_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset every code register is zero, so key 0 hits all nine
		// slots and the first one, move left, must win. The top code is
		// unmapped here.
		send_key(8'h00, 1'b0);
		send_key(8'h00, 1'b1);
		send_key(8'hFF, 1'b0);
		send_key(8'hFF, 1'b1);
		drain();

		// A cap of two: the x speed ramps and saturates, then reverses
		// through zero. Buttons go down, repeat while held, go up, and one
		// goes up without ever having been pressed. Scroll releases are
		// silent.
		program_regs({KEY_DOWN, KEY_UP, KEY_RIGHT, KEY_LEFT},
			{KEY_BTN_M, KEY_BTN_R, KEY_BTN_L}, {KEY_WHL_DN, KEY_WHL_UP}, 5'd2);
		repeat (3) send_key(KEY_RIGHT, 1'b0);
		send_key(KEY_LEFT, 1'b0);
		send_key(KEY_UP, 1'b0);
		send_key(KEY_DOWN, 1'b0);
		send_key(KEY_BTN_L, 1'b0);
		send_key(KEY_BTN_L, 1'b0);
		send_key(KEY_BTN_L, 1'b1);
		send_key(KEY_BTN_R, 1'b1);
		send_key(KEY_BTN_M, 1'b0);
		send_key(KEY_BTN_M, 1'b1);
		send_key(KEY_WHL_UP, 1'b0);
		send_key(KEY_WHL_UP, 1'b1);
		send_key(KEY_WHL_DN, 1'b0);
		drain();

		// A cap of zero: a speed left over from before stays as it is, an
		// opposite press only clears it, and the event still carries the
		// resulting speed.
		program_regs({KEY_DOWN, KEY_UP, KEY_RIGHT, KEY_LEFT},
			{KEY_BTN_M, KEY_BTN_R, KEY_BTN_L}, {KEY_WHL_DN, KEY_WHL_UP}, 5'd0);
		send_key(KEY_LEFT, 1'b0);
		send_key(KEY_RIGHT, 1'b0);
		send_key(KEY_DOWN, 1'b1);
		send_key(KEY_UP, 1'b0);
		drain();

		// Random phases: no idling, a sparse sender, a stalling receiver, and
		// light idling on both sides. Speeds carry over from phase to phase,
		// so the low cap of the second phase meets speeds above it.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					cap       = 5'd31;
				end
				1: begin
					idle_pct  = 85;
					stall_pct = 0;
					cap       = 5'd1;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 85;
					cap       = 5'($urandom_range(31, 1));
				end
				default: begin
					idle_pct  = 6;
					stall_pct = 6;
					cap       = 5'($urandom_range(31, 1));
				end
			endcase
			program_regs($urandom, 24'($urandom), 16'($urandom), cap);
			if (ph == 0) begin
				// Hold the result side off while a run of presses keeps coming.
				hold_req = 1'b1;
				repeat (30) send_key(sb.slot_code(SLOT_MOVE_RIGHT), 1'b0);
			end
			random_items(100);
			if (ph < 3)
				drain();
		end

		// Wait, within bounds, for the last events, then a few more cycles so
		// that any stray extra event is caught by the scoreboard.
		in_valid <= 1'b0;
		for (int w = 0; w < 5000 && sb.pending_events.size() != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending_events.size() != 0)
			sb.report($sformatf("%0d events never arrived", sb.pending_events.size()));

		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of the stimulus above.
	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/kmm_pkg.sv
hw/rtl/kmm_match.sv
hw/rtl/key_to_mouse_event_mapper_top.sv
hw/rtl/kmm_checker.sv
sim/tb.sv
